// ----- design/closest_point_on_cylinder_core_assert.svh -----
// ----------------------------------------------------------------------------
// closest point on cylinder assertion macros
// shared checks with clock and reset taken from the including module
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_CYLINDER_CORE_ASSERT_SVH
`define CLOSEST_POINT_ON_CYLINDER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold on every clock edge out of reset
`define CPC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: check failed");
// condition must never be seen out of reset
`define CPC_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define CPC_ASSERT(label, prop)
`define CPC_NEVER(label, cond)
`endif

`endif

// ----- design/cpc_pkg.sv -----
// ----------------------------------------------------------------------------
// cpc_pkg
// widths, stage counts and word types of the cylinder projection pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpc_pkg;

	// coordinate and register widths
	localparam int COORD_W = 32;
	localparam int MAG_W   = 33;
	localparam int RAD_W   = 31;
	localparam int SQ_W    = 64;
	localparam int ROOT_W  = 32;
	localparam int NUM_W   = 63;

	// normalization is a binary search in even steps: 32, 16, 8, 4, 2 bits
	localparam int NORM_STEPS = 5;
	localparam int E_W        = NORM_STEPS;

	// one result bit per stage
	localparam int SQRT_STAGES = ROOT_W;
	localparam int DIV_STAGES  = 32;

	// per-word flags and z that ride along the pipeline
	typedef struct packed {
		logic               nx;
		logic               ny;
		logic               xz;
		logic               ypos;
		logic [COORD_W-1:0] pz;
	} cpc_side_t;

	// normalization stage contents
	typedef struct packed {
		logic [SQ_W-1:0]  sv;
		logic [E_W-1:0]   e;
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		cpc_side_t        side;
	} cpc_norm_t;

	// contents of the delay line beside the square root
	typedef struct packed {
		logic [NUM_W-1:0] numx;
		logic [NUM_W-1:0] numy;
		cpc_side_t        side;
	} cpc_dly_t;

endpackage

// ----- design/cpc_sqrt.sv -----
// ----------------------------------------------------------------------------
// cpc_sqrt
// pipelined integer square root, floor of the root of a 64-bit value,
// one root bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpc_sqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [cpc_pkg::SQ_W-1:0]   v,
	output logic [cpc_pkg::ROOT_W-1:0] root
);

	localparam int N = cpc_pkg::SQRT_STAGES;

	logic [cpc_pkg::SQ_W-1:0]   rest_s [N];
	logic [33:0]                rem_s  [N];
	logic [cpc_pkg::ROOT_W-1:0] rt_s   [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [cpc_pkg::SQ_W-1:0]   rest_i;
		logic [33:0]                rem_i;
		logic [cpc_pkg::ROOT_W-1:0] rt_i;
		logic [35:0]                cur;
		logic [35:0]                trial;

		// stage input from the port or the previous stage
		if (i == 0) begin : g_first
			assign rest_i = v;
			assign rem_i  = '0;
			assign rt_i   = '0;
		end else begin : g_next
			assign rest_i = rest_s[i-1];
			assign rem_i  = rem_s[i-1];
			assign rt_i   = rt_s[i-1];
		end

		// bring down two bits, try 4*root+1
		assign cur   = {rem_i, rest_i[cpc_pkg::SQ_W-1 -: 2]};
		assign trial = {2'b00, rt_i, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				rest_s[i] <= {rest_i[cpc_pkg::SQ_W-3:0], 2'b00};
				if (cur >= trial) begin
					rem_s[i] <= 34'(cur - trial);
					rt_s[i]  <= {rt_i[cpc_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[i] <= cur[33:0];
					rt_s[i]  <= {rt_i[cpc_pkg::ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = rt_s[N-1];

endmodule

// ----- design/cpc_div.sv -----
// ----------------------------------------------------------------------------
// cpc_div
// pipelined restoring divider, 64-bit dividend by 32-bit divisor,
// one quotient bit per stage; the dividend's upper half must be below the divisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpc_div (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic [31:0] quotient
);

	localparam int N = cpc_pkg::DIV_STAGES;

	logic [31:0] rem_s [N];
	logic [31:0] low_s [N];
	logic [31:0] q_s   [N];
	logic [31:0] d_s   [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [31:0] rem_i;
		logic [31:0] low_i;
		logic [31:0] q_i;
		logic [31:0] d_i;
		logic [32:0] cur;
		logic        ge;

		// stage input from the ports or the previous stage
		if (i == 0) begin : g_first
			assign rem_i = dividend[63:32];
			assign low_i = dividend[31:0];
			assign q_i   = '0;
			assign d_i   = divisor;
		end else begin : g_next
			assign rem_i = rem_s[i-1];
			assign low_i = low_s[i-1];
			assign q_i   = q_s[i-1];
			assign d_i   = d_s[i-1];
		end

		// shift in next dividend bit and compare
		assign cur = {rem_i, low_i[31]};
		assign ge  = cur >= {1'b0, d_i};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? 32'(cur - {1'b0, d_i}) : cur[31:0];
				low_s[i] <= {low_i[30:0], 1'b0};
				q_s[i]   <= {q_i[30:0], ge};
				d_s[i]   <= d_i;
			end
		end
	end

	assign quotient = q_s[N-1];

endmodule

// ----- design/closest_point_on_cylinder_core.sv -----
// ----------------------------------------------------------------------------
// closest_point_on_cylinder_core
// throughput: one word per cycle while the output is not stalled, set by the one-bit-per-stage root and dividers
// the whole pipeline holds while the output word is stalled
// reset clears all valid bits and the radius register to zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "closest_point_on_cylinder_core_assert.svh"

module closest_point_on_cylinder_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [30:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	input  logic signed [31:0] pz,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] cx,
	output logic signed [31:0] cy,
	output logic signed [31:0] cz
);

	localparam int NS   = cpc_pkg::NORM_STEPS;
	localparam int SQN  = cpc_pkg::SQRT_STAGES;
	localparam int DVN  = cpc_pkg::DIV_STAGES;
	localparam int ROOT_STG = 3 + NS + 1 + SQN;
	localparam int LAT  = ROOT_STG + 1 + DVN + 1;

	logic           adv;
	logic [LAT-1:0] vld_s;
	logic [30:0]    rad_q;

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q <= '0;
		end else if (cfg_wr_en) begin
			rad_q <= cfg_wr_data;
		end
	end

	// global advance, valid bits travel with the data
	assign adv      = !(vld_s[LAT-1] && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end
	end

	// s1: magnitudes and flags
	logic [32:0]        ax_in, ay_in;
	logic [32:0]        ax_s1, ay_s1;
	cpc_pkg::cpc_side_t side_in, side_s1;

	assign ax_in = px[31] ? (33'd0 - {px[31], px}) : {1'b0, px};
	assign ay_in = py[31] ? (33'd0 - {py[31], py}) : {1'b0, py};

	always_comb begin
		side_in.nx   = px[31];
		side_in.ny   = py[31];
		side_in.xz   = (px == '0);
		side_in.ypos = !py[31] && (py != '0);
		side_in.pz   = pz;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1   <= ax_in;
			ay_s1   <= ay_in;
			side_s1 <= side_in;
		end
	end

	// s2: squares
	logic [63:0]        sqx_s2, sqy_s2;
	logic [32:0]        ax_s2, ay_s2;
	cpc_pkg::cpc_side_t side_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2  <= 64'(ax_s1) * 64'(ax_s1);
			sqy_s2  <= 64'(ay_s1) * 64'(ay_s1);
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			side_s2 <= side_s1;
		end
	end

	// s3: sum of squares
	logic [63:0]        sum_s3;
	logic [32:0]        ax_s3, ay_s3;
	cpc_pkg::cpc_side_t side_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3  <= sqx_s2 + sqy_s2;
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			side_s3 <= side_s2;
		end
	end

	// s4..s8: even normalizing shift, binary search from wide to narrow
	cpc_pkg::cpc_norm_t norm_src [NS];
	cpc_pkg::cpc_norm_t norm_s   [NS];

	for (genvar k = 0; k < NS; k++) begin : g_norm
		localparam int SH = (2 ** NS) >> k;
		cpc_pkg::cpc_norm_t nxt;

		if (k == 0) begin : g_first
			always_comb begin
				norm_src[0].sv   = sum_s3;
				norm_src[0].e    = '0;
				norm_src[0].ax   = ax_s3;
				norm_src[0].ay   = ay_s3;
				norm_src[0].side = side_s3;
			end
		end else begin : g_next
			assign norm_src[k] = norm_s[k-1];
		end

		always_comb begin
			nxt = norm_src[k];
			if (norm_src[k].sv[63 -: SH] == '0) begin
				nxt.sv = norm_src[k].sv << SH;
				nxt.e  = norm_src[k].e + cpc_pkg::E_W'(SH / 2);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				norm_s[k] <= nxt;
			end
		end
	end

	// s9: scaled magnitudes, root input
	cpc_pkg::cpc_norm_t nl;
	logic [63:0]        shx, shy;
	logic [31:0]        mx_s9, my_s9;
	logic [63:0]        sv_s9;
	cpc_pkg::cpc_side_t side_s9;

	assign nl  = norm_s[NS-1];
	assign shx = {31'd0, nl.ax} << nl.e;
	assign shy = {31'd0, nl.ay} << nl.e;

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s9   <= shx[31:0];
			my_s9   <= shy[31:0];
			sv_s9   <= nl.sv;
			side_s9 <= nl.side;
		end
	end

	// s10..s41: square root of the normalized sum
	logic [31:0] root_s41;

	cpc_sqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.v    (sv_s9),
		.root (root_s41)
	);

	// s10: numerators, radius times scaled magnitude
	cpc_pkg::cpc_dly_t num_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s10.numx <= 63'(mx_s9) * 63'(rad_q);
			num_s10.numy <= 63'(my_s9) * 63'(rad_q);
			num_s10.side <= side_s9;
		end
	end

	// s11..s41: numerators wait for the root
	cpc_pkg::cpc_dly_t dly_s [SQN-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			dly_s[0] <= num_s10;
			for (int i = 1; i < SQN - 1; i++) begin
				dly_s[i] <= dly_s[i-1];
			end
		end
	end

	// s42: rounded dividends
	logic [63:0]        dvx_s42, dvy_s42;
	logic [31:0]        n_s42;
	cpc_pkg::cpc_side_t side_s42;

	always_ff @(posedge clk) begin
		if (adv) begin
			dvx_s42  <= 64'(dly_s[SQN-2].numx) + 64'(root_s41 >> 1);
			dvy_s42  <= 64'(dly_s[SQN-2].numy) + 64'(root_s41 >> 1);
			n_s42    <= root_s41;
			side_s42 <= dly_s[SQN-2].side;
		end
	end

	// s43..s74: the two divisions
	logic [31:0] qx_s74, qy_s74;

	cpc_div u_div_x (
		.clk      (clk),
		.en       (adv),
		.dividend (dvx_s42),
		.divisor  (n_s42),
		.quotient (qx_s74)
	);

	cpc_div u_div_y (
		.clk      (clk),
		.en       (adv),
		.dividend (dvy_s42),
		.divisor  (n_s42),
		.quotient (qy_s74)
	);

	cpc_pkg::cpc_side_t dside_s [DVN];

	always_ff @(posedge clk) begin
		if (adv) begin
			dside_s[0] <= side_s42;
			for (int i = 1; i < DVN; i++) begin
				dside_s[i] <= dside_s[i-1];
			end
		end
	end

	// s75: clamp, sign and the zero-x case
	cpc_pkg::cpc_side_t fs;
	logic [30:0]        magx, magy;
	logic [31:0]        cx_d, cy_d;
	logic [31:0]        cx_s75, cy_s75, cz_s75;

	assign fs   = dside_s[DVN-1];
	assign magx = (qx_s74 > {1'b0, rad_q}) ? rad_q : qx_s74[30:0];
	assign magy = (qy_s74 > {1'b0, rad_q}) ? rad_q : qy_s74[30:0];

	always_comb begin
		if (fs.xz) begin
			cx_d = '0;
			cy_d = fs.ypos ? {1'b0, rad_q} : (32'd0 - {1'b0, rad_q});
		end else begin
			cx_d = fs.nx ? (32'd0 - {1'b0, magx}) : {1'b0, magx};
			cy_d = fs.ny ? (32'd0 - {1'b0, magy}) : {1'b0, magy};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s75 <= cx_d;
			cy_s75 <= cy_d;
			cz_s75 <= fs.pz;
		end
	end

	assign out_valid = vld_s[LAT-1];
	assign cx        = cx_s75;
	assign cy        = cy_s75;
	assign cz        = cz_s75;

	// checks
	`CPC_ASSERT(a_stall_only_when_full, in_stall |-> (out_valid && out_stall))
	`CPC_ASSERT(a_accept_enters_pipe, (in_valid && !in_stall) |=> vld_s[0])
	`CPC_ASSERT(a_root_normalized, (vld_s[ROOT_STG-1] && !dly_s[SQN-2].side.xz) |-> root_s41[31])
	`CPC_NEVER(a_x_within_radius, out_valid && !cx[31] && (cx[30:0] > rad_q))

endmodule

// ----- tb/closest_point_on_cylinder_core_tb.sv -----
// ----------------------------------------------------------------------------
// closest_point_on_cylinder_core_tb
// drives points through the cylinder projection core under random idling and
// a long output hold-off, predicts every result word in place and compares it
// field by field, across several radius settings including both extremes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module closest_point_on_cylinder_core_tb;

	localparam int LATENCY   = 75;
	localparam int N_RANDOM  = 900;
	localparam int CYCLE_MAX = 600000;

	// one expected result word
	typedef struct packed {
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] cz;
	} proj_t;

	// directed row: point plus optional typed-in answer
	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		bit          known;
		proj_t       want;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [30:0]        cfg_wr_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] px, py, pz;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] cx, cy, cz;

	proj_t       expected_q[$];
	logic [30:0] radius_val;
	int          n_bad;
	int          n_words;
	int          n_sent;
	int          cycles;
	int          rx_wait;
	bit          hold_off;

	closest_point_on_cylinder_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.px(px), .py(py), .pz(pz),
		.out_valid(out_valid), .out_stall(out_stall),
		.cx(cx), .cy(cy), .cz(cz)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// bit-serial integer square root of a 64-bit value
	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// scale one magnitude to the radius and restore its sign
	function automatic logic [31:0] scaled(input logic [32:0] m, input bit neg,
			input int e, input logic [63:0] n, input logic [30:0] r);
		logic [127:0] q;
		q = ((128'(m) << e) * 128'(r) + 128'(n >> 1)) / 128'(n);
		if (q > 128'(r)) q = 128'(r);
		return neg ? -q[31:0] : q[31:0];
	endfunction

	// projection of one point onto the cylinder
	function automatic proj_t project(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [30:0] r);
		proj_t p;
		logic [32:0] ax, ay;
		logic [63:0] s, n;
		int e;
		ax = x[31] ? 33'h1_0000_0000 - 33'(x) : 33'(x);
		ay = y[31] ? 33'h1_0000_0000 - 33'(y) : 33'(y);
		p.cz = z;
		if (ax == 0) begin
			p.cx = 0;
			p.cy = (!y[31] && ay != 0) ? {1'b0, r} : -{1'b0, r};
			return p;
		end
		s = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
		e = 0;
		while (s < (64'd1 << 62)) begin
			s = s << 2;
			e++;
		end
		n = isqrt(s);
		p.cx = scaled(ax, x[31], e, n, r);
		p.cy = scaled(ay, y[31], e, n, r);
		return p;
	endfunction

	task automatic report(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch word %0d %s: got %h want %h", n_words, what, got, want);
		n_bad++;
	endtask

	// offer one word and hold it until taken; valid stays up for the next word
	task automatic send_word(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input int gap, input proj_t want);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		px <= x;
		py <= y;
		pz <= z;
		expected_q = {expected_q, want};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_sent++;
	endtask

	task automatic send_point(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input int gap);
		send_word(x, y, z, gap, project(x, y, z, radius_val));
	endtask

	task automatic drain_then_write(input logic [30:0] r);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= r;
		radius_val = r;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 255) - 128;
			1: return 32'h8000_0000 + $urandom_range(0, 3);
			2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			3: return 32'($signed(16'($urandom)));
			default: return $urandom;
		endcase
	endfunction

	// output side: random wait after each taken word and one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait = 0;
		end else if (hold_off) begin
			out_stall <= 1'b1;
		end else if (out_valid && !out_stall) begin
			rx_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
			out_stall <= (rx_wait != 0);
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_stall <= (rx_wait != 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin
		proj_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				report("unexpected word cx", cx, '0);
			end else begin
				want = expected_q.pop_front();
				if (cx !== want.cx) report("cx", cx, want.cx);
				if (cy !== want.cy) report("cy", cy, want.cy);
				if (cz !== want.cz) report("cz", cz, want.cz);
			end
			n_words++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_MAX) begin
			$display("timeout after %0d cycles", cycles);
			$display("closest_point_on_cylinder_core regression: fail");
			$finish;
		end
	end

	// long receiver hold-off in its own process
	initial begin
		hold_off = 1'b0;
		wait (n_sent > 40);
		hold_off = 1'b1;
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		row_t zero_rows[2];
		row_t unit_rows[11];
		row_t rw;
		logic [30:0] radii[5];
		int j;
		n_bad = 0;
		n_words = 0;
		n_sent = 0;
		cycles = 0;
		radius_val = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		px = '0;
		py = '0;
		pz = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset the radius is zero: everything lands on the axis
		zero_rows = '{
			'{32'h0001_0000, 32'h0002_0000, 32'h1234_5678, 1, '{0, 0, 32'h1234_5678}},
			'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, '{0, 0, 32'h8000_0000}}
		};
		foreach (zero_rows[i]) begin
			rw = zero_rows[i];
			send_word(rw.x, rw.y, rw.z, 0, rw.want);
		end

		drain_then_write(31'h0001_0000);
		// zero x picks the nearer pole, origin and negative y go to -radius
		unit_rows = '{
			'{0, 32'h0000_0005, 32'h7FFF_FFFF, 1, '{0, 32'h0001_0000, 32'h7FFF_FFFF}},
			'{0, 32'hFFFF_FFFB, 0, 1, '{0, 32'hFFFF_0000, 0}},
			'{0, 0, 32'h8000_0000, 1, '{0, 32'hFFFF_0000, 32'h8000_0000}},
			'{32'h0003_0000, 0, 1, 1, '{32'h0001_0000, 0, 1}},
			'{32'hFFFD_0000, 0, 2, 1, '{32'hFFFF_0000, 0, 2}},
			'{32'h0003_0000, 32'h0004_0000, 3, 0, '{0, 0, 0}},
			'{32'h8000_0000, 32'h8000_0000, 4, 0, '{0, 0, 0}},
			'{32'h7FFF_FFFF, 32'h8000_0000, 5, 0, '{0, 0, 0}},
			'{32'h0000_0001, 32'h7FFF_FFFF, 6, 0, '{0, 0, 0}},
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 7, 0, '{0, 0, 0}},
			'{32'h0000_0001, 0, 8, 1, '{32'h0001_0000, 0, 8}}
		};
		foreach (unit_rows[i]) begin
			rw = unit_rows[i];
			if (rw.known) begin
				send_word(rw.x, rw.y, rw.z, i % 3, rw.want);
			end else begin
				send_point(rw.x, rw.y, rw.z, i % 3);
			end
		end

		drain_then_write(31'h7FFF_FFFF);
		send_point(32'h8000_0000, 0, 0, 0);
		send_point(0, 32'h7FFF_FFFF, 0, 0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);

		// random points across several radius settings
		radii = '{31'h0000_0000, 31'h7FFF_FFFF, 31'h0001_0000, 31'h0000_0001, 31'h0000_0000};
		for (j = 0; j < N_RANDOM; j++) begin
			if (j % 180 == 0) begin
				radii[4] = 31'($urandom);
				drain_then_write(radii[(j / 180) % 5] == 0 && j != 0 ? radii[4] :
					radii[(j / 180) % 5]);
			end
			send_point(rand_coord(), rand_coord(), $urandom,
				($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0);
		end
		in_valid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("sent %0d points, checked %0d result words, %0d mismatches",
			n_sent, n_words, n_bad);
		$display("covered reset radius, radius extremes, zero x, origin and random points");
		if (n_bad == 0) begin
			$display("closest_point_on_cylinder_core regression: pass");
		end else begin
			$display("closest_point_on_cylinder_core regression: fail");
		end
		$finish;
	end

endmodule
